FILE: src/rtcfa_pkg.sv
`default_nettype none
package rtcfa_pkg;

   localparam int BITS_PER_BYTE       = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [1:0] FUNC_WRITE  = 2'd0;
   localparam logic [1:0] FUNC_READ   = 2'd1;
   localparam logic [1:0] FUNC_SAMPLE = 2'd2;

   localparam logic [1:0] CSR_TWELVE_HOUR = 2'd0;
   localparam logic [1:0] CSR_PM_FLAG     = 2'd1;

   localparam logic [2:0] FIELD_SECONDS = 3'd0;
   localparam logic [2:0] FIELD_HOURS   = 3'd2;
   localparam logic [2:0] FIELD_INVALID = 3'd7;

   // decoded command kinds handed from front to back
   localparam logic [2:0] CMD_REJ_IDLE = 3'd0;
   localparam logic [2:0] CMD_REJ_BUSY = 3'd1;
   localparam logic [2:0] CMD_WRITE    = 3'd2;
   localparam logic [2:0] CMD_READ     = 3'd3;
   localparam logic [2:0] CMD_SAMPLE   = 3'd4;
   localparam logic [2:0] CMD_FINAL    = 3'd5;

   localparam logic [5:0] STEP_WRITE_LAST  = 6'd33;
   localparam logic [5:0] STEP_READ_LAST   = 6'd17;
   localparam logic [5:0] STEP_SAMPLE_LAST = 6'd1;
   localparam logic [5:0] STEP_FINAL_LAST  = 6'd2;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] addr;
      logic [7:0] data;
      logic [7:0] read_value;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic       chip_enable;
      logic       serial_clock;
      logic       io_out;
      logic       io_drive;
      logic [7:0] read_value;
      logic       read_valid;
      logic       rejected;
      logic       last;
   } pins_type;

endpackage
`default_nettype wire

FILE: src/rtcfa_front.sv
`default_nettype none
module rtcfa_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [15:0]       req_tdata,
   input  wire logic [1:0]        req_tuser,
   input  wire logic              csr_valid,
   input  wire logic [1:0]        csr_index,
   input  wire logic              csr_data,
   input  wire logic              queue_full,
   output logic                   push,
   output rtcfa_pkg::cmd_type     push_cmd
);
   import rtcfa_pkg::*;

   logic       twelve_hour_ff, twelve_hour_in;
   logic       pm_flag_ff, pm_flag_in;
   logic [7:0] receive_shift_ff, receive_shift_in;
   logic [3:0] bits_received_ff, bits_received_in;
   logic       reading_active_ff, reading_active_in;
   logic [2:0] read_field_ff, read_field_in;

   logic [1:0]  func;
   logic [2:0]  field;
   logic [6:0]  wval;
   logic        sample;
   logic        accept;
   logic        reject;
   logic [14:0] tens_prod;
   logic [3:0]  tens;
   logic [6:0]  tens_x10;
   logic [3:0]  units;
   logic [7:0]  bcd;
   logic [7:0]  shift_next;
   logic [3:0]  count_next;
   logic [7:0]  byte_masked;
   logic [7:0]  decoded;

   assign func       = req_tuser;
   assign field      = req_tdata[2:0];
   assign wval       = req_tdata[9:3];
   assign sample     = req_tdata[10];
   assign req_tready = ~queue_full;
   assign accept     = req_tvalid & req_tready;
   assign push       = accept;

   always_comb begin
      // tens by reciprocal multiply, exact for seven-bit values
      tens_prod = 15'(wval) * 15'd205;
      tens      = tens_prod[14:11];
      tens_x10  = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
      units     = 4'(wval - tens_x10);
      bcd       = {tens, units};
      if (field == FIELD_HOURS) begin
         if (twelve_hour_ff) begin
            bcd[7] = 1'b1;
            bcd[5] = pm_flag_ff;
         end else begin
            bcd[7] = 1'b0;
         end
      end

      shift_next = receive_shift_ff;
      shift_next[bits_received_ff[2:0]] = sample;
      count_next = bits_received_ff + 4'd1;
      byte_masked = shift_next;
      if (read_field_ff == FIELD_SECONDS || read_field_ff == FIELD_HOURS) begin
         byte_masked[7] = 1'b0;
      end
      decoded = 8'({byte_masked[7:4], 3'b000}) + 8'({byte_masked[7:4], 1'b0})
              + 8'(byte_masked[3:0]);

      priority if (func == FUNC_WRITE || func == FUNC_READ) begin
         reject = (field == FIELD_INVALID) | reading_active_ff;
      end else if (func == FUNC_SAMPLE) begin
         reject = ~reading_active_ff;
      end else begin
         reject = 1'b1;
      end
   end

   always_comb begin
      twelve_hour_in    = twelve_hour_ff;
      pm_flag_in        = pm_flag_ff;
      receive_shift_in  = receive_shift_ff;
      bits_received_in  = bits_received_ff;
      reading_active_in = reading_active_ff;
      read_field_in     = read_field_ff;
      push_cmd.kind       = reading_active_ff ? CMD_REJ_BUSY : CMD_REJ_IDLE;
      push_cmd.addr       = {4'b1000, field, func[0]};
      push_cmd.data       = bcd;
      push_cmd.read_value = decoded;

      if (csr_valid) begin
         if (csr_index == CSR_TWELVE_HOUR) twelve_hour_in = csr_data;
         if (csr_index == CSR_PM_FLAG)     pm_flag_in     = csr_data;
      end

      if (accept && !reject) begin
         unique case (func)
            FUNC_WRITE: begin
               push_cmd.kind = CMD_WRITE;
            end
            FUNC_READ: begin
               push_cmd.kind     = CMD_READ;
               reading_active_in = 1'b1;
               bits_received_in  = 4'd0;
               receive_shift_in  = 8'd0;
               read_field_in     = field;
            end
            default: begin
               receive_shift_in = shift_next;
               if (count_next >= 4'(BITS_PER_BYTE)) begin
                  push_cmd.kind     = CMD_FINAL;
                  reading_active_in = 1'b0;
                  bits_received_in  = 4'd0;
               end else begin
                  push_cmd.kind    = CMD_SAMPLE;
                  bits_received_in = count_next;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         twelve_hour_ff    <= 1'b0;
         pm_flag_ff        <= 1'b0;
         receive_shift_ff  <= 8'd0;
         bits_received_ff  <= 4'd0;
         reading_active_ff <= 1'b0;
         read_field_ff     <= 3'd0;
      end else begin
         twelve_hour_ff    <= twelve_hour_in;
         pm_flag_ff        <= pm_flag_in;
         receive_shift_ff  <= receive_shift_in;
         bits_received_ff  <= bits_received_in;
         reading_active_ff <= reading_active_in;
         read_field_ff     <= read_field_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/rtcfa_queue.sv
`default_nettype none
module rtcfa_queue #(
   parameter int DEPTH = rtcfa_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  rtcfa_pkg::cmd_type             push_cmd,
   input  wire logic                      pop,
   output rtcfa_pkg::cmd_type             head_cmd,
   output rtcfa_pkg::queue_status_type    status
);
   import rtcfa_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head_cmd     = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) store_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/rtcfa_back.sv
`default_nettype none
module rtcfa_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  rtcfa_pkg::cmd_type     head_cmd,
   input  wire logic              head_valid,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rtcfa_pkg::pins_type    rsp_pins
);
   import rtcfa_pkg::*;

   logic [5:0]  step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   pins_type    rsp_pins_ff, rsp_pins_in;

   logic        load;
   logic [5:0]  step_m1;
   logic [15:0] shift_word;
   logic        shift_bit;
   logic        bit_clock;
   logic [5:0]  last_step;
   pins_type    next_pins;

   assign load      = ~rsp_valid_ff | rsp_ready;
   assign step_m1   = step_ff - 6'd1;
   assign shift_word = {head_cmd.data, head_cmd.addr};
   assign shift_bit = shift_word[step_m1[4:1]];
   assign bit_clock = ~step_m1[0];

   always_comb begin
      next_pins = '0;
      last_step = 6'd0;
      unique case (head_cmd.kind)
         CMD_REJ_IDLE: begin
            next_pins.io_drive = 1'b1;
            next_pins.rejected = 1'b1;
         end
         CMD_REJ_BUSY: begin
            next_pins.chip_enable = 1'b1;
            next_pins.rejected    = 1'b1;
         end
         CMD_WRITE: begin
            last_step          = STEP_WRITE_LAST;
            next_pins.io_drive = 1'b1;
            if (step_ff == 6'd0) begin
               next_pins.chip_enable = 1'b1;
            end else if (step_ff != STEP_WRITE_LAST) begin
               next_pins.chip_enable  = 1'b1;
               next_pins.serial_clock = bit_clock;
               next_pins.io_out       = shift_bit;
            end
         end
         CMD_READ: begin
            last_step             = STEP_READ_LAST;
            next_pins.chip_enable = 1'b1;
            if (step_ff == 6'd0) begin
               next_pins.io_drive = 1'b1;
            end else if (step_ff != STEP_READ_LAST) begin
               // drive the address byte; the data line is released after it
               next_pins.io_drive     = 1'b1;
               next_pins.serial_clock = bit_clock;
               next_pins.io_out       = shift_bit;
            end
         end
         CMD_SAMPLE: begin
            last_step              = STEP_SAMPLE_LAST;
            next_pins.chip_enable  = 1'b1;
            next_pins.serial_clock = (step_ff == 6'd0);
         end
         CMD_FINAL: begin
            last_step = STEP_FINAL_LAST;
            if (step_ff == STEP_FINAL_LAST) begin
               next_pins.io_drive   = 1'b1;
               next_pins.read_value = head_cmd.read_value;
               next_pins.read_valid = 1'b1;
            end else begin
               next_pins.chip_enable  = 1'b1;
               next_pins.serial_clock = (step_ff == 6'd0);
            end
         end
         default: begin
            next_pins.io_drive = 1'b1;
            next_pins.rejected = 1'b1;
         end
      endcase
      next_pins.last = (step_ff == last_step);
   end

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pins_in  = rsp_pins_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            rsp_pins_in = next_pins;
            if (next_pins.last) begin
               step_in = 6'd0;
               pop     = 1'b1;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pins_ff <= rsp_pins_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pins  = rsp_pins_ff;

endmodule
`default_nettype wire

FILE: src/rtc_three_wire_field_access.sv
// Three-wire serial master for a real-time-clock chip, one field per request.
// req channel: tuser carries the function (write, read, data-line sample); tdata
//   carries field_select, write_value and io_sample. req_tready falls only when
//   the command queue between the decoder and the pin sequencer is full.
// rsp channel: one word per pin state. tdata carries the pin levels and the
//   decoded read value, tuser the read_valid and rejected flags, tlast marks the
//   final word that belongs to a request.
// csr channel: index 0 selects 12-hour mode, index 1 the PM flag; always ready.
// Words per request: write 34, read 18, sample 2 (3 on the eighth sample),
//   rejected request 1. The pin sequencer's step counter emits one word per
//   cycle unless rsp_tready stalls it or the queue is empty.
// A request's first word passes the command queue, then the output register.
// Requests are decoded on entry and queued (QUEUE_DEPTH entries), so the next
//   request is taken while earlier pin states still stream out.
// A stalled rsp_tready holds the current word and the sequencer; the queue then
//   fills and req_tready drops.
// Reset clears the read state, both configuration bits, the queue and the
//   output valid flag; the output pin word register is not reset.
`default_nettype none
module rtc_three_wire_field_access #(
   parameter int QUEUE_DEPTH = rtcfa_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // field_select[2:0], write_value[9:3], io_sample[10], zero [15:11]
   input  wire logic [15:0] req_tdata,
   // func[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // chip_enable[0], serial_clock[1], io_out[2], io_drive[3], read_value[11:4],
   // zero [15:12]
   output logic [15:0]      rsp_tdata,
   // read_valid[0], rejected[1]
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic        csr_data
);
   import rtcfa_pkg::*;

   cmd_type          push_cmd;
   cmd_type          head_cmd;
   queue_status_type q_status;
   pins_type         rsp_pins;
   logic             push;
   logic             pop;

   assign csr_ready = 1'b1;

   rtcfa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (q_status.full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   rtcfa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   rtcfa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .head_valid (~q_status.empty),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_pins   (rsp_pins)
   );

   assign rsp_tdata = {4'b0000, rsp_pins.read_value, rsp_pins.io_drive, rsp_pins.io_out,
                       rsp_pins.serial_clock, rsp_pins.chip_enable};
   assign rsp_tuser = {rsp_pins.rejected, rsp_pins.read_valid};
   assign rsp_tlast = rsp_pins.last;

   a_final_drops_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_pins.read_valid |-> rsp_pins.last && !rsp_pins.chip_enable)
      else $error("finished read word must be last and drop enable");

   a_reject_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_pins.rejected |-> rsp_pins.last && rsp_pins.read_value == 8'd0)
      else $error("rejected word must be a single last word with no value");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty at once");

   a_accept_queues: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !q_status.empty)
      else $error("accepted request did not reach the queue");

endmodule
`default_nettype wire

FILE: tb/sv/rtc_three_wire_field_access_tb.sv
module rtc_three_wire_field_access_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rtcfa_pkg::*;

   localparam logic [1:0] FUNC_UNUSED     = 2'd3;
   localparam logic [2:0] FIELD_MINUTES   = 3'd1;
   localparam logic [2:0] FIELD_DATE      = 3'd3;
   localparam logic [2:0] FIELD_MONTH     = 3'd4;
   localparam logic [2:0] FIELD_WEEKDAY   = 3'd5;
   localparam logic [2:0] FIELD_YEAR      = 3'd6;
   localparam logic [7:0] ADDR_WRITE_BASE = 8'h80;
   localparam logic [7:0] ADDR_READ_BASE  = 8'h81;
   localparam int DRAIN_PAUSE   = 4;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_ITEMS   = 88;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic        csr_data = 1'b0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatches = 0;

   // shadow of the block's configuration and read state
   logic       hour12 = 1'b0;
   logic       pm = 1'b0;
   logic       rx_active = 1'b0;
   logic [7:0] rx_byte = '0;
   logic [2:0] rx_field = '0;
   int         rx_count = 0;

   pins_type expected_pins[$];
   pins_type burst[$];

   rtc_three_wire_field_access dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic logic [7:0] to_bcd(input int v);
      return 8'(((v / 10) * 16) + (v % 10));
   endfunction

   function automatic logic [7:0] from_bcd(input logic [7:0] b);
      return 8'(b[7:4] * 10 + b[3:0]);
   endfunction

   function automatic void stage(input logic ce, input logic clk, input logic io,
                                 input logic drv, input logic [7:0] rv,
                                 input logic valid, input logic rej);
      pins_type w;
      w.chip_enable  = ce;
      w.serial_clock = clk;
      w.io_out       = io;
      w.io_drive     = drv;
      w.read_value   = rv;
      w.read_valid   = valid;
      w.rejected     = rej;
      w.last         = 1'b0;
      burst.push_back(w);
   endfunction

   // one clock-high and one clock-low state per bit, LSB first
   function automatic void stage_byte(input logic [7:0] b);
      for (int i = 0; i < BITS_PER_BYTE; i++) begin
         stage(1'b1, 1'b1, b[i], 1'b1, 8'd0, 1'b0, 1'b0);
         stage(1'b1, 1'b0, b[i], 1'b1, 8'd0, 1'b0, 1'b0);
      end
   endfunction

   function automatic void predict_pins(input logic [1:0] fn, input logic [2:0] fld,
                                        input logic [6:0] val, input logic smp,
                                        output logic rej);
      logic [7:0] data;
      logic [7:0] b;
      if (fn == FUNC_WRITE || fn == FUNC_READ)
         rej = (fld == FIELD_INVALID) || rx_active;
      else if (fn == FUNC_SAMPLE)
         rej = !rx_active;
      else
         rej = 1'b1;

      if (rej) begin
         if (rx_active)
            stage(1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b1);
         else
            stage(1'b0, 1'b0, 1'b0, 1'b1, 8'd0, 1'b0, 1'b1);
      end else if (fn == FUNC_WRITE) begin
         data = to_bcd(int'(val));
         if (fld == FIELD_HOURS) begin
            if (hour12) begin
               data[7] = 1'b1;
               data[5] = pm;
            end else begin
               data[7] = 1'b0;
            end
         end
         stage(1'b1, 1'b0, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0);
         stage_byte(ADDR_WRITE_BASE + 8'(2 * fld));
         stage_byte(data);
         stage(1'b0, 1'b0, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0);
      end else if (fn == FUNC_READ) begin
         stage(1'b1, 1'b0, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0);
         stage_byte(ADDR_READ_BASE + 8'(2 * fld));
         stage(1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0);
         rx_active = 1'b1;
         rx_count  = 0;
         rx_byte   = '0;
         rx_field  = fld;
      end else begin
         rx_byte[rx_count & 7] = smp;
         rx_count = rx_count + 1;
         stage(1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0);
         stage(1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0);
         if (rx_count >= BITS_PER_BYTE) begin
            b = rx_byte;
            // seconds and hours carry a flag in bit 7
            if (rx_field == FIELD_SECONDS || rx_field == FIELD_HOURS)
               b[7] = 1'b0;
            stage(1'b0, 1'b0, 1'b0, 1'b1, from_bcd(b), 1'b1, 1'b0);
            rx_active = 1'b0;
            rx_count  = 0;
         end
      end

      burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i])
         expected_pins.push_back(burst[i]);
      burst.delete();
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   task automatic check_word();
      pins_type want;
      if (expected_pins.size() == 0) begin
         report_mismatch("word with none expected", int'(rsp_tdata), 0);
      end else begin
         want = expected_pins.pop_front();
         if (rsp_tdata[0] !== want.chip_enable)
            report_mismatch("chip_enable", rsp_tdata[0], want.chip_enable);
         if (rsp_tdata[1] !== want.serial_clock)
            report_mismatch("serial_clock", rsp_tdata[1], want.serial_clock);
         if (rsp_tdata[2] !== want.io_out)
            report_mismatch("io_out", rsp_tdata[2], want.io_out);
         if (rsp_tdata[3] !== want.io_drive)
            report_mismatch("io_drive", rsp_tdata[3], want.io_drive);
         if (rsp_tdata[11:4] !== want.read_value)
            report_mismatch("read_value", rsp_tdata[11:4], want.read_value);
         if (rsp_tuser[0] !== want.read_valid)
            report_mismatch("read_valid", rsp_tuser[0], want.read_valid);
         if (rsp_tuser[1] !== want.rejected)
            report_mismatch("rejected", rsp_tuser[1], want.rejected);
         if (rsp_tlast !== want.last)
            report_mismatch("last", rsp_tlast, want.last);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_word();
   end

   task automatic send_word(input logic [1:0] fn, input logic [2:0] fld,
                            input logic [6:0] val, input logic smp, output logic taken);
      logic rej;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {5'd0, smp, val, fld};
      do @(posedge clock); while (!req_tready);
      predict_pins(fn, fld, val, smp, rej);
      taken = !rej;
   endtask

   // hold the request side until every expected word is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_pins.size() != 0)
         @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic write_config(input logic tm, input logic pm_bit);
      csr_valid <= 1'b1;
      csr_index <= CSR_TWELVE_HOUR;
      csr_data  <= tm;
      do @(posedge clock); while (!csr_ready);
      hour12 = tm;
      csr_index <= CSR_PM_FLAG;
      csr_data  <= pm_bit;
      do @(posedge clock); while (!csr_ready);
      pm = pm_bit;
      csr_valid <= 1'b0;
   endtask

   task automatic test_field_edges();
      logic t;
      send_word(FUNC_WRITE, FIELD_SECONDS, 7'd0, 1'b0, t);
      send_word(FUNC_WRITE, FIELD_YEAR, 7'd99, 1'b1, t);
      send_word(FUNC_WRITE, FIELD_DATE, 7'd127, 1'b0, t);
      send_word(FUNC_WRITE, FIELD_HOURS, 7'd23, 1'b0, t);
      send_word(FUNC_WRITE, FIELD_INVALID, 7'd45, 1'b0, t);
      send_word(FUNC_READ, FIELD_INVALID, 7'd0, 1'b0, t);
      send_word(FUNC_UNUSED, FIELD_WEEKDAY, 7'd127, 1'b1, t);
      send_word(FUNC_SAMPLE, FIELD_MONTH, 7'd0, 1'b1, t);
   endtask

   task automatic test_read_while_busy();
      logic t;
      send_word(FUNC_READ, FIELD_HOURS, 7'd127, 1'b1, t);
      send_word(FUNC_WRITE, FIELD_MINUTES, 7'd10, 1'b0, t);
      send_word(FUNC_READ, FIELD_DATE, 7'd0, 1'b1, t);
      send_word(FUNC_UNUSED, FIELD_SECONDS, 7'd0, 1'b0, t);
      // all ones: the flag bit must be stripped for hours
      for (int i = 0; i < BITS_PER_BYTE; i++)
         send_word(FUNC_SAMPLE, FIELD_INVALID, 7'd127, 1'b1, t);
      // all ones on minutes gives the largest decoded value
      send_word(FUNC_READ, FIELD_MINUTES, 7'd0, 1'b0, t);
      for (int i = 0; i < BITS_PER_BYTE; i++)
         send_word(FUNC_SAMPLE, FIELD_SECONDS, 7'd0, 1'b1, t);
   endtask

   task automatic test_hour_format();
      logic [1:0] modes[4];
      logic       t;
      modes[0] = 2'b10;
      modes[1] = 2'b11;
      modes[2] = 2'b01;
      modes[3] = 2'b00;
      send_idle_pct = 18;
      rsp_stall_pct = 18;
      foreach (modes[m]) begin
         drain_results();
         write_config(modes[m][1], modes[m][0]);
         send_word(FUNC_WRITE, FIELD_HOURS, 7'd23, 1'b0, t);
         send_word(FUNC_WRITE, FIELD_HOURS, 7'd12, 1'b1, t);
         send_word(FUNC_WRITE, FIELD_HOURS, 7'($urandom_range(127)), 1'b0, t);
         send_word(FUNC_READ, FIELD_HOURS, 7'd0, 1'b0, t);
         for (int i = 0; i < BITS_PER_BYTE; i++)
            send_word(FUNC_SAMPLE, FIELD_HOURS, 7'd0, 1'($urandom_range(1)), t);
      end
   endtask

   task automatic test_random_traffic();
      int         send_pct[4];
      int         stall_pct[4];
      int         taken_count;
      int         r;
      logic [1:0] fn;
      logic [2:0] fld;
      logic [6:0] val;
      logic       smp;
      logic       t;
      send_pct  = '{0, 53, 0, 18};
      stall_pct = '{0, 0, 53, 18};
      for (int p = 0; p < 4; p++) begin
         drain_results();
         write_config(1'($urandom_range(1)), 1'($urandom_range(1)));
         send_idle_pct = send_pct[p];
         rsp_stall_pct = stall_pct[p];
         taken_count = 0;
         while (taken_count < PHASE_ITEMS) begin
            fld = 3'($urandom_range(6));
            val = ($urandom_range(9) < 8) ? 7'($urandom_range(99)) : 7'($urandom_range(127));
            smp = 1'($urandom_range(1));
            r   = $urandom_range(99);
            if (!rx_active) begin
               if (r < 62) begin
                  fn = FUNC_WRITE;
               end else if (r < 92) begin
                  fn = FUNC_READ;
               end else begin
                  // noise: bad field, unused function, sample with no read open
                  case (r % 3)
                     0: begin
                        fn  = 2'($urandom_range(1));
                        fld = FIELD_INVALID;
                     end
                     1: fn = FUNC_UNUSED;
                     default: fn = FUNC_SAMPLE;
                  endcase
               end
            end else begin
               if (r < 90)
                  fn = FUNC_SAMPLE;
               else if (r < 94)
                  fn = FUNC_WRITE;
               else if (r < 97)
                  fn = FUNC_READ;
               else
                  fn = FUNC_UNUSED;
               fld = 3'($urandom_range(7));
            end
            send_word(fn, fld, val, smp, t);
            if (t)
               taken_count++;
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_edges();
      test_read_while_busy();
      test_hour_format();
      test_random_traffic();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_pins.size() != 0)
         report_mismatch("words never seen", expected_pins.size(), 0);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

FILE: files.f
src/rtcfa_pkg.sv
src/rtcfa_front.sv
src/rtcfa_queue.sv
src/rtcfa_back.sv
src/rtc_three_wire_field_access.sv
tb/sv/rtc_three_wire_field_access_tb.sv
